FILE: design/mfs_pkg.sv
// Shared types and constants for the multilevel feedback scheduler.
// Used by mfs_ctrl, mfs_datapath and the top level; depends on nothing.
package mfs_pkg;

  localparam logic [2:0] OP_ADMIT  = 3'd0;
  localparam logic [2:0] OP_EXPIRE = 3'd1;
  localparam logic [2:0] OP_IO     = 3'd2;
  localparam logic [2:0] OP_FINISH = 3'd3;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVENT  = 3'd1;
  localparam logic [2:0] ST_RREAD  = 3'd2;
  localparam logic [2:0] ST_RCHECK = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;
  localparam logic [2:0] ST_DSTEP  = 3'd5;
  localparam logic [2:0] ST_DTAKE  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_Q1   = 3'd0;
  localparam logic [2:0] REG_Q2   = 3'd1;
  localparam logic [2:0] REG_Q3   = 3'd2;
  localparam logic [2:0] REG_P1   = 3'd3;
  localparam logic [2:0] REG_P2   = 3'd4;
  localparam logic [2:0] REG_P3   = 3'd5;
  localparam logic [2:0] REG_WAIT = 3'd6;

  typedef struct packed {
    logic [7:0] quantum1;
    logic [7:0] quantum2;
    logic [7:0] quantum3;
    logic [3:0] passes1;
    logic [3:0] passes2;
    logic [3:0] passes3;
    logic [7:0] io_wait;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic event_step;
    logic release_step;
    logic dispatch_fix;
    logic dispatch_step;
    logic dispatch_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic release_more;
    logic dispatch_need;
    logic dispatch_pop;
    logic out_free;
  } sts_t;

endpackage

FILE: design/mfs_ctrl.sv
// Controller state machine of the multilevel feedback scheduler.
// Depends on mfs_pkg; drives commands to mfs_datapath and reads its status.
module mfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfs_pkg::sts_t sts,
  output mfs_pkg::cmd_t cmd
);

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == mfs_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      mfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = mfs_pkg::ST_EVENT;
        end
      end
      mfs_pkg::ST_EVENT: begin
        cmd.event_step = 1'b1;
        state_next = mfs_pkg::ST_RREAD;
      end
      // This state waits for the registered read of the waiting head to come out of the memory.
      mfs_pkg::ST_RREAD: state_next = mfs_pkg::ST_RCHECK;
      mfs_pkg::ST_RCHECK: begin
        cmd.release_step = 1'b1;
        state_next = sts.release_more ? mfs_pkg::ST_RREAD : mfs_pkg::ST_DSTART;
      end
      mfs_pkg::ST_DSTART: begin
        cmd.dispatch_fix = 1'b1;
        state_next = sts.dispatch_need ? mfs_pkg::ST_DSTEP : mfs_pkg::ST_FINISH;
      end
      mfs_pkg::ST_DSTEP: begin
        cmd.dispatch_step = 1'b1;
        if (sts.dispatch_pop) state_next = mfs_pkg::ST_DTAKE;
      end
      mfs_pkg::ST_DTAKE: begin
        cmd.dispatch_take = 1'b1;
        state_next = mfs_pkg::ST_FINISH;
      end
      mfs_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = mfs_pkg::ST_IDLE;
        end
      end
      default: state_next = mfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mfs_pkg::ST_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> state == mfs_pkg::ST_IDLE) else $error("accept outside idle");
  a_event_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == mfs_pkg::ST_EVENT) else $error("event step missing");
  a_take_after_pop: assert property (@(posedge clk) disable iff (rst)
    (cmd.dispatch_step && sts.dispatch_pop) |=> cmd.dispatch_take)
    else $error("dispatch pop not taken");
`endif

endmodule

FILE: design/mfs_datapath.sv
// Datapath of the multilevel feedback scheduler: queue memories, queue pointers,
// running task, round position and result register. Depends on mfs_pkg.
module mfs_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 6,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mfs_pkg::cfg_t        cfg,
  input  mfs_pkg::cmd_t        cmd,
  output mfs_pkg::sts_t        sts,
  input  logic [2:0]           in_opcode,
  input  logic [TAG_BITS-1:0]  in_tag,
  input  logic [TIME_BITS-1:0] in_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_disp,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic [1:0]           out_level,
  output logic [7:0]           out_quantum,
  output logic                 out_all_done,
  output logic                 out_full
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);

  // Ready queue memories and the waiting queue (tag, stamp, return level).
  logic [TAG_BITS-1:0]  mem1 [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  mem2 [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  mem3 [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  wmem_tag [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] wmem_stamp [QUEUE_DEPTH];
  logic [1:0]           wmem_level [QUEUE_DEPTH];

  logic [TAG_BITS-1:0]  rd1, rd2, rd3, wrd_tag;
  logic [TIME_BITS-1:0] wrd_stamp;
  logic [1:0]           wrd_level;

  logic [AW-1:0] head [4];
  logic [CW-1:0] cnt  [4];
  logic [AW-1:0] head_next [4];
  logic [CW-1:0] cnt_next  [4];

  logic                 run_v, run_v_next;
  logic [TAG_BITS-1:0]  run_tag;
  logic [1:0]           run_lv, run_lv_next;
  logic [5:0]           phase, phase_next;
  logic [CW-1:0]        prem, prem_next;
  logic [CW-1:0]        live, live_next;
  logic                 full_f, full_next;
  logic [1:0]           take_lv, take_lv_next;

  logic [2:0]           op;
  logic [TAG_BITS-1:0]  tag_in;
  logic [TIME_BITS-1:0] now;

  // Single write port into the ready memories.
  logic [2:0]          rwr_en;
  logic [AW-1:0]       rwr_addr;
  logic [TAG_BITS-1:0] rwr_data;
  logic                wwr_en;

  logic [3:0] p1, p2, p3;
  logic [5:0] total, phase_inc;
  logic [1:0] cur_lv;
  logic [CW-1:0] cur_cnt, eff;
  logic [TIME_BITS-1:0] age;
  logic aged;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] c);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(c);
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] h);
    logic [AW:0] s;
    s = (AW+1)'(h) + 1'b1;
    if (s >= DEPTH_W) s = '0;
    return s[AW-1:0];
  endfunction

  always_comb begin
    p1 = (cfg.passes1 == 4'd0) ? 4'd1 : cfg.passes1;
    p2 = (cfg.passes2 == 4'd0) ? 4'd1 : cfg.passes2;
    p3 = (cfg.passes3 == 4'd0) ? 4'd1 : cfg.passes3;
    total = 6'(p1) + 6'(p2) + 6'(p3);
    phase_inc = (phase + 6'd1 == total) ? 6'd0 : phase + 6'd1;
    if (phase < 6'(p1)) cur_lv = 2'd1;
    else if (phase < 6'(p1) + 6'(p2)) cur_lv = 2'd2;
    else cur_lv = 2'd3;
    cur_cnt = cnt[cur_lv - 2'd1];
    eff = (prem == '0) ? cur_cnt : prem;
    age = now - wrd_stamp;
    aged = (cnt[3] != '0) && (age >= TIME_BITS'(cfg.io_wait));
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      head_next[i] = head[i];
      cnt_next[i]  = cnt[i];
    end
    run_v_next   = run_v;
    run_lv_next  = run_lv;
    phase_next   = phase;
    prem_next    = prem;
    live_next    = live;
    full_next    = full_f;
    take_lv_next = take_lv;
    rwr_en   = '0;
    rwr_addr = '0;
    rwr_data = '0;
    wwr_en   = 1'b0;
    sts      = '0;
    sts.out_free = !out_valid || out_ready;

    if (cmd.load_in) full_next = 1'b0;

    if (cmd.event_step) begin
      if (op == mfs_pkg::OP_ADMIT) begin
        if (live >= DEPTH_C || cnt[0] >= DEPTH_C) begin
          full_next = 1'b1;
        end else begin
          rwr_en[0] = 1'b1;
          rwr_addr  = slot(head[0], cnt[0]);
          rwr_data  = tag_in;
          cnt_next[0] = cnt[0] + 1'b1;
          live_next = live + 1'b1;
        end
      end else if ((op == mfs_pkg::OP_EXPIRE || op == mfs_pkg::OP_IO ||
                    op == mfs_pkg::OP_FINISH) && run_v) begin
        run_v_next = 1'b0;
        if (op == mfs_pkg::OP_EXPIRE) begin
          // Demotion: level one goes to two, two and three go to three.
          if (run_lv >= 2'd2) begin
            if (cnt[2] >= DEPTH_C) begin
              full_next = 1'b1;
              if (live != '0) live_next = live - 1'b1;
            end else begin
              rwr_en[2] = 1'b1;
              rwr_addr  = slot(head[2], cnt[2]);
              rwr_data  = run_tag;
              cnt_next[2] = cnt[2] + 1'b1;
            end
          end else begin
            if (cnt[1] >= DEPTH_C) begin
              full_next = 1'b1;
              if (live != '0) live_next = live - 1'b1;
            end else begin
              rwr_en[1] = 1'b1;
              rwr_addr  = slot(head[1], cnt[1]);
              rwr_data  = run_tag;
              cnt_next[1] = cnt[1] + 1'b1;
            end
          end
        end else if (op == mfs_pkg::OP_IO) begin
          if (cnt[3] >= DEPTH_C) begin
            full_next = 1'b1;
            if (live != '0) live_next = live - 1'b1;
          end else begin
            wwr_en = 1'b1;
            cnt_next[3] = cnt[3] + 1'b1;
          end
        end else begin
          if (live != '0) live_next = live - 1'b1;
        end
      end
    end

    if (cmd.release_step && aged) begin
      if (cnt[wrd_level - 2'd1] >= DEPTH_C) begin
        full_next = 1'b1;
      end else begin
        rwr_en[wrd_level - 2'd1] = 1'b1;
        rwr_addr = slot(head[wrd_level - 2'd1], cnt[wrd_level - 2'd1]);
        rwr_data = wrd_tag;
        cnt_next[wrd_level - 2'd1] = cnt[wrd_level - 2'd1] + 1'b1;
        head_next[3] = inc(head[3]);
        cnt_next[3]  = cnt[3] - 1'b1;
        sts.release_more = 1'b1;
      end
    end

    if (cmd.dispatch_fix) begin
      sts.dispatch_need = !run_v && (cnt[0] != '0 || cnt[1] != '0 || cnt[2] != '0);
      if (sts.dispatch_need && phase >= total) begin
        phase_next = '0;
        prem_next  = '0;
      end
    end

    if (cmd.dispatch_step) begin
      if (cur_cnt == '0) begin
        prem_next  = '0;
        phase_next = phase_inc;
      end else begin
        sts.dispatch_pop = 1'b1;
        head_next[cur_lv - 2'd1] = inc(head[cur_lv - 2'd1]);
        cnt_next[cur_lv - 2'd1]  = cur_cnt - 1'b1;
        prem_next = eff - 1'b1;
        if (eff == CW'(1)) phase_next = phase_inc;
        run_v_next   = 1'b1;
        run_lv_next  = cur_lv;
        take_lv_next = cur_lv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rwr_en[0]) mem1[rwr_addr] <= rwr_data;
    if (rwr_en[1]) mem2[rwr_addr] <= rwr_data;
    if (rwr_en[2]) mem3[rwr_addr] <= rwr_data;
    if (wwr_en) begin
      wmem_tag[slot(head[3], cnt[3])]   <= run_tag;
      wmem_stamp[slot(head[3], cnt[3])] <= now;
      wmem_level[slot(head[3], cnt[3])] <= (run_lv >= 2'd3) ? 2'd2 : 2'd1;
    end
    rd1       <= mem1[head[0]];
    rd2       <= mem2[head[1]];
    rd3       <= mem3[head[2]];
    wrd_tag   <= wmem_tag[head[3]];
    wrd_stamp <= wmem_stamp[head[3]];
    wrd_level <= wmem_level[head[3]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op     <= in_opcode;
      tag_in <= in_tag;
      now    <= in_time;
    end
    if (cmd.dispatch_take) begin
      unique case (take_lv)
        2'd1:    run_tag <= rd1;
        2'd2:    run_tag <= rd2;
        default: run_tag <= rd3;
      endcase
    end
    if (cmd.out_load) begin
      out_disp     <= take_lv != 2'd0;
      out_tag      <= (take_lv != 2'd0) ? run_tag : '0;
      out_level    <= take_lv;
      unique case (take_lv)
        2'd1:    out_quantum <= (cfg.quantum1 == 8'd0) ? 8'd1 : cfg.quantum1;
        2'd2:    out_quantum <= (cfg.quantum2 == 8'd0) ? 8'd1 : cfg.quantum2;
        2'd3:    out_quantum <= (cfg.quantum3 == 8'd0) ? 8'd1 : cfg.quantum3;
        default: out_quantum <= 8'd0;
      endcase
      out_all_done <= live == '0;
      out_full     <= full_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
      run_v     <= 1'b0;
      run_lv    <= 2'd1;
      phase     <= '0;
      prem      <= '0;
      live      <= '0;
      full_f    <= 1'b0;
      take_lv   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        head[i] <= head_next[i];
        cnt[i]  <= cnt_next[i];
      end
      run_v   <= run_v_next;
      run_lv  <= run_lv_next;
      phase   <= phase_next;
      prem    <= prem_next;
      live    <= live_next;
      full_f  <= full_next;
      // A zero level marks that nothing was dispatched for this word.
      take_lv <= cmd.load_in ? 2'd0 : take_lv_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= DEPTH_C) else $error("live count overflow");
  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[3] <= DEPTH_C) else $error("waiting queue overflow");
  a_pop_sets_run: assert property (@(posedge clk) disable iff (rst)
    sts.dispatch_pop |=> run_v) else $error("dispatch left no running task");
`endif

endmodule

FILE: design/multilevel_feedback_scheduler.sv
// Multilevel feedback scheduler: takes one event word and returns one result word.
// After a word is accepted the controller applies the event, then reads and checks the
// waiting head, going round this release loop once for each task released to a ready
// queue, with one waiting-queue memory read per head. It then starts the dispatch and, if a
// task is needed, steps through the passes, skipping empty ones, until a task is popped and
// taken, and loads the result register. A new word can be accepted once the result is loaded.
// No clearing pass is needed after reset. The next event is taken while a result still
// waits, and the controller holds in its last state until the result register is free.
// Depends on mfs_pkg, mfs_ctrl and mfs_datapath.
module multilevel_feedback_scheduler #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 6,
  parameter int TIME_BITS   = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((TAG_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata, // task_tag, now_time
  input  logic [2:0] s_tuser,                             // opcode
  output logic m_tvalid,
  input  logic m_tready,
  // dispatch_tag, dispatch_level, dispatch_quantum, all_done, queue_full
  output logic [((TAG_BITS+12+7)/8)*8-1:0] m_tdata,
  output logic m_tuser,                                   // dispatch_valid
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int OW = ((TAG_BITS + 12 + 7) / 8) * 8;

  mfs_pkg::cfg_t cfg;
  mfs_pkg::cmd_t cmd;
  mfs_pkg::sts_t sts;
  logic [TAG_BITS-1:0] o_tag;
  logic [1:0] o_level;
  logic [7:0] o_quantum;
  logic o_done, o_full;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quantum1 <= 8'd1;
      cfg.quantum2 <= 8'd2;
      cfg.quantum3 <= 8'd4;
      cfg.passes1  <= 4'd4;
      cfg.passes2  <= 4'd2;
      cfg.passes3  <= 4'd1;
      cfg.io_wait  <= 8'd3;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        mfs_pkg::REG_Q1:   cfg.quantum1 <= pwdata[7:0];
        mfs_pkg::REG_Q2:   cfg.quantum2 <= pwdata[7:0];
        mfs_pkg::REG_Q3:   cfg.quantum3 <= pwdata[7:0];
        mfs_pkg::REG_P1:   cfg.passes1  <= pwdata[3:0];
        mfs_pkg::REG_P2:   cfg.passes2  <= pwdata[3:0];
        mfs_pkg::REG_P3:   cfg.passes3  <= pwdata[3:0];
        mfs_pkg::REG_WAIT: cfg.io_wait  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfs_pkg::REG_Q1:   prdata = 32'(cfg.quantum1);
      mfs_pkg::REG_Q2:   prdata = 32'(cfg.quantum2);
      mfs_pkg::REG_Q3:   prdata = 32'(cfg.quantum3);
      mfs_pkg::REG_P1:   prdata = 32'(cfg.passes1);
      mfs_pkg::REG_P2:   prdata = 32'(cfg.passes2);
      mfs_pkg::REG_P3:   prdata = 32'(cfg.passes3);
      mfs_pkg::REG_WAIT: prdata = 32'(cfg.io_wait);
      default:           prdata = '0;
    endcase
  end

  mfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (s_tuser),
    .in_tag       (s_tdata[TAG_BITS-1:0]),
    .in_time      (s_tdata[TAG_BITS+TIME_BITS-1:TAG_BITS]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_disp     (m_tuser),
    .out_tag      (o_tag),
    .out_level    (o_level),
    .out_quantum  (o_quantum),
    .out_all_done (o_done),
    .out_full     (o_full)
  );

  assign m_tdata = OW'({o_full, o_done, o_quantum, o_level, o_tag});

endmodule

FILE: test/multilevel_feedback_scheduler_tb.sv
// Self-checking testbench for the multilevel feedback scheduler: drives event words,
// predicts each dispatch result in a scoreboard class and compares it with the output.
// Depends on mfs_pkg and the multilevel_feedback_scheduler RTL.
module multilevel_feedback_scheduler_tb;

  localparam int DEPTH = 64;
  localparam logic [2:0] OP_TICK = 3'd4;

  typedef struct {
    logic       dvalid;
    logic [5:0] dtag;
    logic [1:0] dlevel;
    logic [7:0] dquant;
    logic       done;
    logic       full;
  } sched_result_t;

  class sched_scoreboard;
    logic [5:0]  rq [3][DEPTH];
    logic [5:0]  wtag [DEPTH];
    logic [31:0] wstamp [DEPTH];
    logic [1:0]  wlvl [DEPTH];
    int          head [4];
    int          cnt [4];
    bit          run_v;
    logic [5:0]  run_tag;
    logic [1:0]  run_lvl;
    int          phase, pass_left, live;
    logic [7:0]  regs [mfs_pkg::NUM_REGS];
    sched_result_t pending [$];
    int          errors;

    function void clear();
      for (int i = 0; i < 4; i++) begin
        head[i] = 0;
        cnt[i] = 0;
      end
      run_v = 0;
      run_tag = 0;
      run_lvl = 1;
      phase = 0;
      pass_left = 0;
      live = 0;
      regs[mfs_pkg::REG_Q1] = 1; regs[mfs_pkg::REG_Q2] = 2; regs[mfs_pkg::REG_Q3] = 4;
      regs[mfs_pkg::REG_P1] = 4; regs[mfs_pkg::REG_P2] = 2; regs[mfs_pkg::REG_P3] = 1;
      regs[mfs_pkg::REG_WAIT] = 3;
      errors = 0;
    endfunction

    function int one_min(int v);
      return (v == 0) ? 1 : v;
    endfunction

    function bit push_ready(int lv, logic [5:0] t);
      if (cnt[lv-1] >= DEPTH) return 0;
      rq[lv-1][(head[lv-1] + cnt[lv-1]) % DEPTH] = t;
      cnt[lv-1]++;
      return 1;
    endfunction

    function int level_at(int p);
      int n1, n2;
      n1 = one_min(regs[mfs_pkg::REG_P1]);
      n2 = one_min(regs[mfs_pkg::REG_P2]);
      if (p < n1) return 1;
      if (p < n1 + n2) return 2;
      return 3;
    endfunction

    // Notes an accepted event and queues the result it causes.
    function void note_event(logic [2:0] op, logic [5:0] tag, logic [31:0] now);
      sched_result_t r;
      int total, lv, s;
      r = '{0, 0, 0, 0, 0, 0};
      if (op == mfs_pkg::OP_ADMIT) begin
        if (live >= DEPTH || !push_ready(1, tag)) r.full = 1;
        else live++;
      end else if (op >= mfs_pkg::OP_EXPIRE && op <= mfs_pkg::OP_FINISH && run_v) begin
        run_v = 0;
        if (op == mfs_pkg::OP_EXPIRE) begin
          if (!push_ready(run_lvl >= 2 ? 3 : 2, run_tag)) begin
            r.full = 1;
            if (live > 0) live--;
          end
        end else if (op == mfs_pkg::OP_IO) begin
          if (cnt[3] >= DEPTH) begin
            r.full = 1;
            if (live > 0) live--;
          end else begin
            s = (head[3] + cnt[3]) % DEPTH;
            wtag[s] = run_tag;
            wstamp[s] = now;
            wlvl[s] = (run_lvl >= 2'd3) ? 2'd2 : 2'd1;
            cnt[3]++;
          end
        end else if (live > 0) live--;
      end
      // Aged waiting heads rejoin in order; the oldest blocks the rest.
      while (cnt[3] > 0) begin
        s = head[3];
        if ((now - wstamp[s]) < {24'd0, regs[mfs_pkg::REG_WAIT]}) break;
        if (!push_ready(wlvl[s], wtag[s])) begin
          r.full = 1;
          break;
        end
        head[3] = (head[3] + 1) % DEPTH;
        cnt[3]--;
      end
      if (!run_v && (cnt[0] + cnt[1] + cnt[2]) != 0) begin
        total = one_min(regs[mfs_pkg::REG_P1]) + one_min(regs[mfs_pkg::REG_P2]) +
                one_min(regs[mfs_pkg::REG_P3]);
        if (phase >= total) begin
          phase = 0;
          pass_left = 0;
        end
        for (int g = 0; g <= 2 * total + 1 && !r.dvalid; g++) begin
          lv = level_at(phase);
          if (pass_left == 0) begin
            pass_left = cnt[lv-1];
            if (pass_left == 0) begin
              phase = (phase + 1) % total;
              continue;
            end
          end
          if (cnt[lv-1] == 0) begin
            pass_left = 0;
            phase = (phase + 1) % total;
            continue;
          end
          r.dtag = rq[lv-1][head[lv-1]];
          head[lv-1] = (head[lv-1] + 1) % DEPTH;
          cnt[lv-1]--;
          r.dlevel = 2'(lv);
          r.dquant = 8'(one_min(regs[lv-1]));
          r.dvalid = 1;
          run_v = 1;
          run_tag = r.dtag;
          run_lvl = 2'(lv);
          pass_left--;
          if (pass_left == 0) phase = (phase + 1) % total;
        end
      end
      r.done = (live == 0);
      pending.push_back(r);
    endfunction

    function void check_result(logic uflag, logic [23:0] d);
      sched_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result word %h/%b", d, uflag);
        return;
      end
      e = pending.pop_front();
      if (uflag !== e.dvalid || d[5:0] !== e.dtag || d[7:6] !== e.dlevel ||
          d[15:8] !== e.dquant || d[16] !== e.done || d[17] !== e.full) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp v=%b tag=%0d lvl=%0d q=%0d done=%b full=%b, %s",
                   e.dvalid, e.dtag, e.dlevel, e.dquant, e.done, e.full,
                   $sformatf("got v=%b tag=%0d lvl=%0d q=%0d done=%b full=%b",
                             uflag, d[5:0], d[7:6], d[15:8], d[16], d[17]));
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // task_tag [5:0], now_time [37:6]
  logic [2:0]  s_tuser = '0;  // opcode
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;       // tag, level, quantum, all_done, queue_full
  logic        m_tuser;       // dispatch_valid
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sb;
  int          send_idle = 0, recv_idle = 0;
  int          hold_cycles = 0;
  logic [31:0] clock_s = 0;

  multilevel_feedback_scheduler DUT (.*);

  always #6 clk = ~clk;

  // Receiver: random stalls plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.regs[idx] = v;
  endtask

  // The word stays offered after its accepting edge; the next call or drain
  // replaces or withdraws it in the same time step.
  task automatic send_event(logic [2:0] op, logic [5:0] tag, logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {2'b00, now, tag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(op, tag, now);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Random mixed traffic: admits, scheduling events, ticks and undefined opcodes.
  task automatic random_events(int n);
    logic [2:0] op;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 25) op = mfs_pkg::OP_ADMIT;
      else if (k < 45) op = mfs_pkg::OP_EXPIRE;
      else if (k < 65) op = mfs_pkg::OP_IO;
      else if (k < 78) op = mfs_pkg::OP_FINISH;
      else if (k < 95) op = OP_TICK;
      else op = 3'($urandom_range(7, 5));
      clock_s += 32'($urandom_range(3));
      send_event(op, 6'($urandom_range(63)),
                 ($urandom_range(30) == 0) ? 32'($urandom) : clock_s);
    end
  endtask

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: events with nothing running, tag extremes, a burst of admits.
    send_event(mfs_pkg::OP_FINISH, 6'd0, 32'd0);
    send_event(mfs_pkg::OP_EXPIRE, 6'd63, 32'hFFFF_FFFF);
    send_event(mfs_pkg::OP_ADMIT, 6'd0, 32'd1);
    send_event(mfs_pkg::OP_ADMIT, 6'd63, 32'd2);
    send_event(mfs_pkg::OP_EXPIRE, 6'd0, 32'd3);
    send_event(mfs_pkg::OP_IO, 6'd0, 32'd4);
    send_event(OP_TICK, 6'd0, 32'd5);
    send_event(3'd7, 6'd42, 32'd9);
    send_event(mfs_pkg::OP_IO, 6'd21, 32'hFFFF_FFFE);
    send_event(mfs_pkg::OP_FINISH, 6'd0, 32'd3);
    send_event(mfs_pkg::OP_FINISH, 6'd0, 32'd10);
    for (int i = 0; i < 14; i++) send_event(mfs_pkg::OP_ADMIT, 6'(i), 32'd20);
    drain();

    write_reg(mfs_pkg::REG_Q1, 8'd255); write_reg(mfs_pkg::REG_Q2, 8'd0);
    write_reg(mfs_pkg::REG_Q3, 8'd1);
    write_reg(mfs_pkg::REG_P1, 8'd15); write_reg(mfs_pkg::REG_P2, 8'd0);
    write_reg(mfs_pkg::REG_P3, 8'd15);
    write_reg(mfs_pkg::REG_WAIT, 8'd0);

    // Fill past 64 live tasks while the receiver holds off.
    hold_cycles <= 400;
    for (int i = 0; i < 60; i++)
      send_event(mfs_pkg::OP_ADMIT, 6'($urandom_range(63)), 32'd30);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 62; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 62; end
        default: begin send_idle = 11; recv_idle = 11; end
      endcase
      random_events(130);
      drain();
      write_reg(mfs_pkg::REG_Q1, 8'($urandom_range(255)));
      write_reg(mfs_pkg::REG_Q2, 8'($urandom_range(255)));
      write_reg(mfs_pkg::REG_Q3, 8'($urandom_range(255)));
      write_reg(mfs_pkg::REG_P1, 8'($urandom_range(15)));
      write_reg(mfs_pkg::REG_P2, 8'($urandom_range(15)));
      write_reg(mfs_pkg::REG_P3, (ph == 3) ? 8'd1 : 8'($urandom_range(15)));
      write_reg(mfs_pkg::REG_WAIT, (ph == 1) ? 8'd255 : 8'($urandom_range(8)));
    end
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 60; i++) begin
      clock_s += 32'd1;
      send_event(3'($urandom_range(4)), 6'($urandom_range(63)), clock_s);
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: multilevel_feedback_scheduler.f
design/mfs_pkg.sv
design/mfs_ctrl.sv
design/mfs_datapath.sv
design/multilevel_feedback_scheduler.sv
test/multilevel_feedback_scheduler_tb.sv
